FILE: sv/bmpp_pkg.sv
// Shared types and constants of the BMP byte-stream pixel parser.
`timescale 1ns / 1ps

package bmpp_pkg;

  // Largest accepted image width or height.
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  // "BM" read little-endian from file bytes 0 and 1.
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;

  // Both headers together; the pixel data can start no earlier.
  localparam logic [31:0] HEADER_BYTES = 32'd54;

  // File positions at which a header field's last byte arrives.
  localparam logic [31:0] POS_SIGNATURE = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_BITCOUNT  = 32'd29;
  localparam logic [31:0] POS_LAST_HDR  = HEADER_BYTES - 32'd1;

  localparam logic [15:0] BITS_24 = 16'd24;
  localparam logic [15:0] BITS_32 = 16'd32;
  localparam logic [2:0]  BPP_24  = 3'd3;
  localparam logic [2:0]  BPP_32  = 3'd4;
  localparam logic [2:0]  BPP_NONE = 3'd0;

  typedef enum logic [2:0] {
    KIND_PIXEL      = 3'd0,
    KIND_BAD_SIG    = 3'd1,
    KIND_BAD_OFFSET = 3'd2,
    KIND_BAD_DEPTH  = 3'd3,
    KIND_TOO_LARGE  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } res_t;

endpackage

FILE: sv/bmpp_core.sv
// Parser state and the next-state and result logic for one file byte.
`timescale 1ns / 1ps

module bmpp_core #(
  parameter int unsigned MaxDim = bmpp_pkg::MAX_DIM_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     data_byte_i,
  input  logic           file_start_i,
  output logic           res_valid_o,
  output bmpp_pkg::res_t res_o
);
  import bmpp_pkg::*;

  // Dimensions are held saturated at MaxDim + 1.
  localparam int unsigned DimW = $clog2(MaxDim + 2);
  localparam logic [DimW-1:0] DimMax = DimW'(MaxDim);
  localparam logic [DimW-1:0] DimSat = DimW'(MaxDim + 1);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [31:0]     pos;
    logic [31:0]     offset;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [2:0]      bpp;
    logic [DimW-1:0] col;
    logic [DimW-1:0] row;
    logic [1:0]      bip;
    logic [1:0]      pad;
    logic [15:0]     held;
    logic [31:0]     shift;
  } st_t;

  st_t st_q, st_d, cur;

  logic [31:0]     sh;
  logic [31:0]     pos_inc;
  logic [DimW-1:0] sat_val;
  logic [DimW-1:0] col_inc;
  logic [DimW-1:0] row_inc;
  logic [31:0]     col_ext;
  logic [31:0]     y_ext;
  logic [3:0]      pad_prod;
  logic [1:0]      pad_val;
  logic [1:0]      pad_dec;

  always_comb begin
    cur = st_q;
    if (file_start_i) begin
      cur = '0;
    end

    sh       = {data_byte_i, cur.shift[31:8]};
    pos_inc  = cur.pos + 32'd1;
    sat_val  = (sh > 32'(MaxDim)) ? DimSat : sh[DimW-1:0];
    col_inc  = cur.col + DimW'(1);
    row_inc  = cur.row + DimW'(1);
    col_ext  = 32'(cur.col);
    y_ext    = 32'(cur.height) - 32'd1 - 32'(cur.row);
    pad_prod = {2'b00, cur.bpp[1:0]} * {2'b00, cur.width[1:0]};
    pad_val  = 2'd0 - pad_prod[1:0];
    pad_dec  = cur.pad - 2'd1;

    st_d        = cur;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (cur.phase)
      PH_HEADER: begin
        st_d.shift = sh;
        st_d.pos   = pos_inc;
        if (cur.pos == POS_SIGNATURE) begin
          if (sh[31:16] != BMP_SIGNATURE) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_SIG;
            st_d.phase  = PH_IDLE;
          end
        end else if (cur.pos == POS_OFFSET) begin
          st_d.offset = sh;
        end else if (cur.pos == POS_WIDTH) begin
          st_d.width = sat_val;
        end else if (cur.pos == POS_HEIGHT) begin
          st_d.height = sat_val;
        end else if (cur.pos == POS_BITCOUNT) begin
          if (sh[31:16] == BITS_24) begin
            st_d.bpp = BPP_24;
          end else if (sh[31:16] == BITS_32) begin
            st_d.bpp = BPP_32;
          end else begin
            st_d.bpp = BPP_NONE;
          end
        end else if (cur.pos == POS_LAST_HDR) begin
          if (cur.offset < HEADER_BYTES) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_OFFSET;
            st_d.phase  = PH_IDLE;
          end else if (cur.bpp == BPP_NONE) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_DEPTH;
            st_d.phase  = PH_IDLE;
          end else if (cur.width > DimMax || cur.height > DimMax) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_TOO_LARGE;
            st_d.phase  = PH_IDLE;
          end else if (cur.width == '0 || cur.height == '0) begin
            st_d.phase = PH_IDLE;
          end else if (cur.offset == HEADER_BYTES) begin
            st_d.phase = PH_PIXEL;
          end else begin
            st_d.phase = PH_SKIP;
          end
        end
      end

      PH_SKIP: begin
        st_d.pos = pos_inc;
        if (pos_inc == cur.offset) begin
          st_d.phase = PH_PIXEL;
        end
      end

      PH_PIXEL: begin
        case (cur.bip)
          2'd0: st_d.held = {8'h00, data_byte_i};
          2'd1: st_d.held = {data_byte_i, cur.held[7:0]};
          2'd2: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PIXEL;
            res_o.x     = col_ext[11:0];
            res_o.y     = y_ext[11:0];
            res_o.red   = data_byte_i;
            res_o.green = cur.held[15:8];
            res_o.blue  = cur.held[7:0];
            res_o.last  = (col_inc == cur.width) && (row_inc == cur.height);
          end
          default: ;  // alpha byte of a 32-bit pixel is dropped
        endcase
        if (({1'b0, cur.bip} + 3'd1) >= cur.bpp) begin
          st_d.bip = 2'd0;
          st_d.col = col_inc;
          if (col_inc >= cur.width) begin
            st_d.pad = pad_val;
            if (pad_val != 2'd0) begin
              st_d.phase = PH_PAD;
            end else begin
              st_d.col   = '0;
              st_d.row   = row_inc;
              st_d.phase = (row_inc >= cur.height) ? PH_IDLE : PH_PIXEL;
            end
          end
        end else begin
          st_d.bip = cur.bip + 2'd1;
        end
      end

      PH_PAD: begin
        st_d.pad = pad_dec;
        if (pad_dec == 2'd0) begin
          st_d.col   = '0;
          st_d.row   = row_inc;
          st_d.phase = (row_inc >= cur.height) ? PH_IDLE : PH_PIXEL;
        end
      end

      default: ;  // idle: bytes are dropped until the next file start
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: sv/bmp_byte_stream_pixel_parser.sv
// Top level of the BMP byte-stream pixel parser: input register, parser, result register.
`timescale 1ns / 1ps
// Throughput: one file byte per cycle, sustained, as long as the result side takes results.
// Path: a byte transfer is captured in the input register; the result it causes is
// then captured in the result register and presented on the master side.
// The parser state advances once per byte between those two registers.
// Reset: asynchronous and active low; it empties both registers and leaves the parser
// waiting for byte 0 of a file's header.

module bmp_byte_stream_pixel_parser #(
  parameter int unsigned MaxDim = bmpp_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: one file byte per transfer.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] file_start
  // Master side: one result per transfer.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [11:0] pixel_x, [23:12] pixel_y, [31:24] pixel_red,
                                        // [39:32] pixel_green, [47:40] pixel_blue
  output logic [2:0]  m_axis_tuser_o,   // [2:0] result_kind
  output logic        m_axis_tlast_o    // last_pixel
);
  import bmpp_pkg::*;

  // Input register. It drains whenever the result register is empty or being emptied, so
  // a byte is accepted into an empty input register even while a finished result still
  // waits on the master side.
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  logic advance;
  logic step;

  // Parser output for the byte in the input register.
  logic res_valid;
  res_t res;

  // Result register.
  logic out_v_q;
  res_t out_q;

  assign advance         = !out_v_q || m_axis_tready_i;
  assign step            = in_v_q && advance;
  assign s_axis_tready_o = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // The parser state moves by one byte for every byte that leaves the input register.
  bmpp_core #(
    .MaxDim(MaxDim)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .file_start_i(in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Most bytes cause no result; only those that do fill the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.blue, out_q.green, out_q.red, out_q.y, out_q.x};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

  // With the result register empty, the input side must never stall.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");

  // Error results carry no last-pixel flag.
  a_error_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind != KIND_PIXEL) |-> !out_q.last)
    else $error("error result flagged as last pixel");

  // The final pixel of a bottom-up image is the rightmost one of the top row.
  a_last_on_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind == KIND_PIXEL && out_q.last) |-> (out_q.y == 12'd0))
    else $error("last pixel not on the top row");

  // A result can only be loaded while the result side is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i) |=> (out_v_q && $stable(out_q)))
    else $error("pending result overwritten");

endmodule
